>>> hw/rtl/pst_pkg.sv
`default_nettype none
package pst_pkg;

    // Fixed field widths of the interface.
    localparam int VAL_W     = 10;
    localparam int VER_W     = 11;
    localparam int RANK_W    = 11;
    localparam int ANS_W     = 11;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Parameter defaults.
    localparam int DEF_MAX_VERSIONS = 1024;
    localparam int DEF_POOL_NODES   = 16384;

    // Depth of the pending-subrange stack used by the range count walk.
    localparam int STK_DEPTH = 16;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RANK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_RANK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_HIGH = 2'd1;

    // Midpoint of a value interval, as the tree splits it.
    function automatic logic [VAL_W-1:0] mid_of(input logic [VAL_W-1:0] lo,
                                                input logic [VAL_W-1:0] hi);
        logic [VAL_W:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        return s[VAL_W:1];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pst_pool.sv
`default_nettype none
// Node pool: two registered read ports, one write port. Node zero is the
// null node and always reads as zero; it is never written.
module pst_pool
    import pst_pkg::*;
#(
    parameter int POOL_NODES = DEF_POOL_NODES,
    parameter int WORD_W     = 39
) (
    input  wire logic                          i_clk,
    input  wire logic [$clog2(POOL_NODES)-1:0] i_ra,
    input  wire logic [$clog2(POOL_NODES)-1:0] i_rb,
    output logic      [WORD_W-1:0]             o_da,
    output logic      [WORD_W-1:0]             o_db,
    input  wire logic                          i_we,
    input  wire logic [$clog2(POOL_NODES)-1:0] i_wa,
    input  wire logic [WORD_W-1:0]             i_wd
);
    logic [WORD_W-1:0] r_mem [POOL_NODES];
    logic [WORD_W-1:0] r_qa;
    logic [WORD_W-1:0] r_qb;
    logic              r_za;
    logic              r_zb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_qa <= r_mem[i_ra];
        r_qb <= r_mem[i_rb];
        r_za <= (i_ra == '0);
        r_zb <= (i_rb == '0);
    end

    assign o_da = r_za ? '0 : r_qa;
    assign o_db = r_zb ? '0 : r_qb;
endmodule
`default_nettype wire

>>> hw/rtl/pst_roots.sv
`default_nettype none
// Root table: one root node per version, registered read.
module pst_roots
    import pst_pkg::*;
#(
    parameter int MAX_VERSIONS = DEF_MAX_VERSIONS,
    parameter int NODE_W       = 14
) (
    input  wire logic                               i_clk,
    input  wire logic [$clog2(MAX_VERSIONS+1)-1:0]  i_ra,
    output logic      [NODE_W-1:0]                  o_rd,
    input  wire logic                               i_we,
    input  wire logic [$clog2(MAX_VERSIONS+1)-1:0]  i_wa,
    input  wire logic [NODE_W-1:0]                  i_wd
);
    logic [NODE_W-1:0] r_mem [MAX_VERSIONS+1];
    logic [NODE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_q <= r_mem[i_ra];
    end

    assign o_rd = r_q;
endmodule
`default_nettype wire

>>> hw/rtl/persistent_segment_tree_kth.sv
`default_nettype none
// Persistent value-domain segment tree with k-th smallest and range count.
// Command channel: an item is taken at a rising edge where start is high and
// busy is low. busy stays high until the result is shown. Each item gives one
// result on o_answer, o_new_version and o_status, valid for exactly the one
// cycle in which o_done is high; the receiver cannot stall it.
// Configuration: i_cfg_valid with i_cfg_index and i_cfg_data writes domain_low
// (index 0) or domain_high (index 1); o_cfg_ready is always high, and writes
// are expected only while the block is idle. Other indexes are ignored.
// Work per item, with D the number of tree levels of the current domain (11
// for a full 10-bit domain): an insert makes a sizing pass over the levels,
// then one pool read and one pool write per level. A k-th query makes per
// level one read of the node pair and one read of the left children, through
// the two read ports of the node pool. A range count visits the nodes of the
// range decomposition, each with a check and, where the node overlaps the
// range, a read of the node pair. A new item can be taken in the cycle in
// which the result of the previous one is shown.
// All work is sequenced by one controller that reuses the same midpoint,
// compare and subtract logic at every level. Reset clears the version and node
// counters and returns the domain to 0..1023; the memories need no clearing.
module persistent_segment_tree_kth
    import pst_pkg::*;
#(
    parameter int MAX_VERSIONS = DEF_MAX_VERSIONS,
    parameter int POOL_NODES   = DEF_POOL_NODES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [VAL_W-1:0]     i_value,
    input  wire logic [VER_W-1:0]     i_base_version,
    input  wire logic [VER_W-1:0]     i_older_version,
    input  wire logic [VER_W-1:0]     i_newer_version,
    input  wire logic [VAL_W-1:0]     i_range_lo,
    input  wire logic [VAL_W-1:0]     i_range_hi,
    input  wire logic [RANK_W-1:0]    i_rank,
    output logic                      o_done,
    output logic      [ANS_W-1:0]     o_answer,
    output logic      [VER_W-1:0]     o_new_version,
    output logic      [STAT_W-1:0]    o_status,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VAL_W-1:0]     i_cfg_data
);
    localparam int NW     = $clog2(POOL_NODES);
    localparam int VW     = $clog2(MAX_VERSIONS + 1);
    localparam int CNT_W  = $clog2(MAX_VERSIONS + 1);
    localparam int WORD_W = CNT_W + 2 * NW;
    localparam int CW     = (VW > VER_W) ? VW : VER_W;
    localparam int KW     = CNT_W + 6;
    localparam int LEN_W  = $clog2(VAL_W + 2);
    localparam int SP_W   = $clog2(STK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_LEN, S_IROOT, S_IWALK, S_QA, S_QB,
        S_RC_CHK, S_RC_DATA, S_K_NODE, S_K_LEFT, S_FIN
    } t_state;

    typedef struct packed {
        logic [NW-1:0]    a;
        logic [NW-1:0]    b;
        logic [VAL_W-1:0] l;
        logic [VAL_W-1:0] r;
    } t_frame;

    t_state r_state, n_state;

    logic [VAL_W-1:0]  r_dom_lo, r_dom_hi;
    logic [KIND_W-1:0] r_kind;
    logic [VAL_W-1:0]  r_value, r_lo, r_hi;
    logic [VER_W-1:0]  r_base, r_newv;
    logic [NW-1:0]     r_nc, n_nc;
    logic [VW-1:0]     r_vc, n_vc;
    logic [VAL_W-1:0]  r_l, n_l, r_r, n_r;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [NW-1:0]     r_a, n_a, r_b, n_b;
    logic [NW-1:0]     r_al, n_al, r_bl, n_bl, r_ar, n_ar, r_br, n_br;
    logic [NW-1:0]     r_cur, n_cur, r_root, n_root;
    logic              r_rvalid, n_rvalid;
    logic              r_first, n_first;
    logic signed [KW-1:0] r_k, n_k;
    logic signed [KW-1:0] r_sum, n_sum;
    logic [SP_W-1:0]   r_sp, n_sp;
    t_frame            r_stk [STK_DEPTH];
    logic              stk_push;
    t_frame            stk_wd;
    t_frame            stk_top;

    logic              r_done, n_done;
    logic [ANS_W-1:0]  r_answer, n_answer;
    logic [VER_W-1:0]  r_newver, n_newver;
    logic [STAT_W-1:0] r_status, n_status;

    logic [NW-1:0]     pool_ra, pool_rb, pool_wa;
    logic [WORD_W-1:0] pool_da, pool_db, pool_wd;
    logic              pool_we;
    logic [VW-1:0]     root_ra, root_wa;
    logic [NW-1:0]     root_rd, root_wd;
    logic              root_we;

    logic [CNT_W-1:0]  na_cnt, nb_cnt;
    logic [NW-1:0]     na_l, na_r, nb_l, nb_r;
    logic signed [CNT_W:0] diff;
    logic [VAL_W-1:0]  mid;
    logic [NW-1:0]     root_now;

    assign {na_cnt, na_l, na_r} = pool_da;
    assign {nb_cnt, nb_l, nb_r} = pool_db;
    assign diff     = $signed({1'b0, nb_cnt}) - $signed({1'b0, na_cnt});
    assign mid      = mid_of(r_l, r_r);
    assign root_now = r_rvalid ? root_rd : '0;
    assign stk_top  = r_stk[r_sp - SP_W'(1)];

    // A version reads as a stored root only if it exists.
    function automatic logic ver_ok(input logic [VER_W-1:0] v, input logic [VW-1:0] vc);
        return (v != '0) && (CW'(v) <= CW'(vc));
    endfunction

    pst_pool #(.POOL_NODES(POOL_NODES), .WORD_W(WORD_W)) u_pool (
        .i_clk (i_clk),
        .i_ra  (pool_ra),
        .i_rb  (pool_rb),
        .o_da  (pool_da),
        .o_db  (pool_db),
        .i_we  (pool_we),
        .i_wa  (pool_wa),
        .i_wd  (pool_wd)
    );

    pst_roots #(.MAX_VERSIONS(MAX_VERSIONS), .NODE_W(NW)) u_roots (
        .i_clk (i_clk),
        .i_ra  (root_ra),
        .o_rd  (root_rd),
        .i_we  (root_we),
        .i_wa  (root_wa),
        .i_wd  (root_wd)
    );

    always_comb begin
        logic signed [KW-1:0] x;
        logic [NW:0]          need;
        logic [VW-1:0]        vnext;
        n_state  = r_state;
        n_nc     = r_nc;
        n_vc     = r_vc;
        n_l      = r_l;
        n_r      = r_r;
        n_len    = r_len;
        n_a      = r_a;
        n_b      = r_b;
        n_al     = r_al;
        n_bl     = r_bl;
        n_ar     = r_ar;
        n_br     = r_br;
        n_cur    = r_cur;
        n_root   = r_root;
        n_rvalid = r_rvalid;
        n_first  = r_first;
        n_k      = r_k;
        n_sum    = r_sum;
        n_sp     = r_sp;
        n_done   = 1'b0;
        n_answer = r_answer;
        n_newver = r_newver;
        n_status = r_status;
        stk_push = 1'b0;
        stk_wd   = '0;
        pool_ra  = '0;
        pool_rb  = '0;
        pool_we  = 1'b0;
        pool_wa  = r_cur;
        pool_wd  = '0;
        root_ra  = '0;
        root_we  = 1'b0;
        root_wa  = '0;
        root_wd  = r_root;
        x        = KW'(diff);
        need     = {1'b0, r_nc} + (NW+1)'(r_len);
        vnext    = r_vc + VW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_l      = r_dom_lo;
                    n_r      = r_dom_hi;
                    n_answer = '0;
                    n_newver = '0;
                    n_status = ST_OK;
                    n_sum    = '0;
                    n_sp     = '0;
                    n_k      = KW'(i_rank);
                    n_first  = 1'b1;
                    priority if (i_kind == KIND_INSERT) begin
                        n_len   = LEN_W'(1);
                        n_state = S_LEN;
                    end else if (i_kind == KIND_COUNT || i_kind == KIND_RANK) begin
                        root_ra  = VW'(i_older_version);
                        n_rvalid = ver_ok(i_older_version, r_vc);
                        n_state  = S_QA;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LEN: begin
                if (r_l < r_r) begin
                    if (r_value <= mid) begin
                        n_r = mid;
                    end else begin
                        n_l = mid + VAL_W'(1);
                    end
                    n_len = r_len + LEN_W'(1);
                end else begin
                    n_l = r_dom_lo;
                    n_r = r_dom_hi;
                    if (CW'(r_vc) >= CW'(MAX_VERSIONS) || need > (NW+1)'(POOL_NODES - 1)) begin
                        n_status = ST_FULL;
                        n_state  = S_FIN;
                    end else begin
                        root_ra  = VW'(r_base);
                        n_rvalid = ver_ok(r_base, r_vc);
                        n_cur    = r_nc + NW'(1);
                        n_root   = r_nc + NW'(1);
                        n_state  = S_IROOT;
                    end
                end
            end
            S_IROOT: begin
                pool_ra = root_now;
                n_state = S_IWALK;
            end
            S_IWALK: begin
                pool_we = 1'b1;
                if (r_l < r_r) begin
                    if (r_value <= mid) begin
                        pool_ra = na_l;
                        pool_wd = {na_cnt + CNT_W'(1), r_cur + NW'(1), na_r};
                        n_r     = mid;
                    end else begin
                        pool_ra = na_r;
                        pool_wd = {na_cnt + CNT_W'(1), na_l, r_cur + NW'(1)};
                        n_l     = mid + VAL_W'(1);
                    end
                    n_cur = r_cur + NW'(1);
                end else begin
                    pool_wd  = {na_cnt + CNT_W'(1), na_l, na_r};
                    n_nc     = r_cur;
                    n_vc     = vnext;
                    root_we  = 1'b1;
                    root_wa  = vnext;
                    n_newver = VER_W'(vnext);
                    n_state  = S_FIN;
                end
            end
            S_QA: begin
                n_a      = root_now;
                root_ra  = VW'(r_newv);
                n_rvalid = ver_ok(r_newv, r_vc);
                n_state  = S_QB;
            end
            S_QB: begin
                n_b = root_now;
                if (r_kind == KIND_COUNT) begin
                    n_state = S_RC_CHK;
                end else begin
                    pool_ra = r_a;
                    pool_rb = root_now;
                    n_state = S_K_NODE;
                end
            end
            S_RC_CHK: begin
                if (r_lo > r_hi || r_hi < r_l || r_lo > r_r) begin
                    if (r_sp != '0) begin
                        n_a     = stk_top.a;
                        n_b     = stk_top.b;
                        n_l     = stk_top.l;
                        n_r     = stk_top.r;
                        n_sp    = r_sp - SP_W'(1);
                    end else begin
                        n_answer = r_sum[KW-1] ? '0 : ANS_W'(r_sum);
                        n_state  = S_FIN;
                    end
                end else begin
                    pool_ra = r_a;
                    pool_rb = r_b;
                    n_state = S_RC_DATA;
                end
            end
            S_RC_DATA: begin
                n_state = S_RC_CHK;
                if ((r_lo <= r_l && r_r <= r_hi) || r_l >= r_r) begin
                    if (r_lo <= r_l && r_r <= r_hi) begin
                        n_sum = r_sum + KW'(diff);
                    end
                    if (r_sp != '0) begin
                        n_a  = stk_top.a;
                        n_b  = stk_top.b;
                        n_l  = stk_top.l;
                        n_r  = stk_top.r;
                        n_sp = r_sp - SP_W'(1);
                    end else begin
                        n_sum    = r_sum + ((r_lo <= r_l && r_r <= r_hi) ? KW'(diff) : '0);
                        n_answer = n_sum[KW-1] ? '0 : ANS_W'(n_sum);
                        n_state  = S_FIN;
                    end
                end else if (r_lo <= mid) begin
                    if (r_hi > mid) begin
                        stk_push = 1'b1;
                        stk_wd   = '{a: na_r, b: nb_r, l: mid + VAL_W'(1), r: r_r};
                        n_sp     = r_sp + SP_W'(1);
                    end
                    n_a = na_l;
                    n_b = nb_l;
                    n_r = mid;
                end else begin
                    n_a = na_r;
                    n_b = nb_r;
                    n_l = mid + VAL_W'(1);
                end
            end
            S_K_NODE: begin
                n_first = 1'b0;
                if (r_first && (r_k == '0 || r_k > KW'(diff))) begin
                    n_status = ST_BAD_RANK;
                    n_state  = S_FIN;
                end else if (r_l < r_r) begin
                    n_al    = na_l;
                    n_bl    = nb_l;
                    n_ar    = na_r;
                    n_br    = nb_r;
                    pool_ra = na_l;
                    pool_rb = nb_l;
                    n_state = S_K_LEFT;
                end else begin
                    n_answer = ANS_W'(r_l);
                    n_state  = S_FIN;
                end
            end
            S_K_LEFT: begin
                if (r_k <= x) begin
                    n_a = r_al;
                    n_b = r_bl;
                    n_r = mid;
                end else begin
                    n_a = r_ar;
                    n_b = r_br;
                    n_l = mid + VAL_W'(1);
                    n_k = r_k - x;
                end
                pool_ra = n_a;
                pool_rb = n_b;
                n_state = S_K_NODE;
            end
            S_FIN: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nc     <= '0;
            r_vc     <= '0;
            r_sp     <= '0;
            r_done   <= 1'b0;
            r_dom_lo <= '0;
            r_dom_hi <= '1;
        end else begin
            r_state <= n_state;
            r_nc    <= n_nc;
            r_vc    <= n_vc;
            r_sp    <= n_sp;
            r_done  <= n_done;
            if (i_cfg_valid && i_cfg_index == REG_DOMAIN_LOW) begin
                r_dom_lo <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == REG_DOMAIN_HIGH) begin
                r_dom_hi <= i_cfg_data;
            end
        end
        if (r_state == S_IDLE && start) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_base  <= i_base_version;
            r_newv  <= i_newer_version;
            r_lo    <= i_range_lo;
            r_hi    <= i_range_hi;
        end
        if (stk_push) begin
            r_stk[r_sp] <= stk_wd;
        end
        r_l      <= n_l;
        r_r      <= n_r;
        r_len    <= n_len;
        r_a      <= n_a;
        r_b      <= n_b;
        r_al     <= n_al;
        r_bl     <= n_bl;
        r_ar     <= n_ar;
        r_br     <= n_br;
        r_cur    <= n_cur;
        r_root   <= n_root;
        r_rvalid <= n_rvalid;
        r_first  <= n_first;
        r_k      <= n_k;
        r_sum    <= n_sum;
        r_answer <= n_answer;
        r_newver <= n_newver;
        r_status <= n_status;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_done        = r_done;
    assign o_answer      = r_answer;
    assign o_new_version = r_newver;
    assign o_status      = r_status;
endmodule
`default_nettype wire

>>> hw/rtl/pst_chk.sv
`default_nettype none
// Port-level checks of the command channel and the result fields.
module pst_chk
    import pst_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_done,
    input wire logic [ANS_W-1:0]  o_answer,
    input wire logic [VER_W-1:0]  o_new_version,
    input wire logic [STAT_W-1:0] o_status
);
    // An accepted item always keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted item did not make block busy");

    // A result is shown only once the block has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result shown while busy");

    // Results are single-cycle strobes.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    // A failed item carries no answer and no version.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_FULL || o_status == ST_BAD_RANK)
        |-> o_answer == '0 && o_new_version == '0)
        else $error("failed item carries data");
endmodule

bind persistent_segment_tree_kth pst_chk u_pst_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_answer      (o_answer),
    .o_new_version (o_new_version),
    .o_status      (o_status)
);
`default_nettype wire
